// ===== rtl/core/lgeb_pkg.sv =====
// shared types, constants and curve table of the envelope bank
package lgeb_pkg;

    localparam int unsigned NUM_VOICES       = 5;
    localparam int unsigned CURVE_TABLE_SIZE = 256;

    localparam int unsigned VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int unsigned KIDX_W = $clog2(CURVE_TABLE_SIZE + 1);

    localparam logic [15:0] ONE_Q15       = 16'd32768;
    localparam logic [15:0] STRIKE_FLOOR  = 16'd1638;
    localparam logic [15:0] SILENCE_LIMIT = 16'd26;
    localparam logic [16:0] FULL_Q16      = 17'd65536;
    localparam logic [12:0] CUT_BASE      = 13'd300;
    localparam logic [12:0] CUT_SPAN      = 13'd7700;

    localparam logic [15:0] DECAY_RESET  = 16'd55508;
    localparam logic [15:0] ATTACK_RESET = 16'd45511;
    localparam logic [15:0] FOLD_RESET   = 16'd36044;
    localparam logic [15:0] COUPLE_RESET = 16'd65535;

    localparam logic [1:0] REG_DECAY  = 2'd0;
    localparam logic [1:0] REG_ATTACK = 2'd1;
    localparam logic [1:0] REG_FOLD   = 2'd2;
    localparam logic [1:0] REG_COUPLE = 2'd3;

    localparam logic [1:0] KIND_LEVEL   = 2'd0;
    localparam logic [1:0] KIND_SILENCE = 2'd1;
    localparam logic [1:0] KIND_PITCH   = 2'd2;

    typedef enum logic [2:0] {
        B_IDLE,
        B_STRIKE,
        B_LEVEL,
        B_CHECK,
        B_CURVE,
        B_MIX,
        B_CUT,
        B_EMIT
    } t_bstate;

    typedef struct packed {
        logic       strike;
        logic [6:0] pitch;
    } t_cmd;

    typedef struct packed {
        logic [15:0] decay_factor;
        logic [15:0] attack_step;
        logic [15:0] fold_amount;
        logic [15:0] couple_amount;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  voice;
        logic [6:0]  note;
        logic [14:0] volume;
        logic [12:0] cutoff_hz;
        logic [15:0] drive;
        logic        last;
    } t_result;

    typedef logic [16:0] t_curve_tab [0:CURVE_TABLE_SIZE];

    function automatic t_curve_tab f_build_curve();
        t_curve_tab   tab;
        logic [63:0]  x;
        logic [63:0]  target;
        logic [63:0]  m;
        logic [63:0]  p;
        logic [63:0]  y;
        logic [31:0]  lo;
        logic [31:0]  hi;
        logic [31:0]  mid;
        for (int k = 0; k <= int'(CURVE_TABLE_SIZE); k++) begin
            x      = (64'(k) * 64'd65536) / CURVE_TABLE_SIZE;
            target = x << 44;
            lo     = 32'd0;
            hi     = 32'd4096;
            while (lo < hi) begin
                mid = (lo + hi + 32'd1) >> 1;
                m   = 64'(mid);
                if (m * m * m * m * m <= target) begin
                    lo = mid;
                end else begin
                    hi = mid - 32'd1;
                end
            end
            p = 64'd0;
            if (x != 64'd0 && lo != 32'd0) begin
                p = (x * 64'd4096) / 64'(lo);
                if (p > 64'd65536) p = 64'd65536;
            end
            y = (p * p) >> 16;
            if (y > 64'd65536) y = 64'd65536;
            tab[k] = y[16:0];
        end
        return tab;
    endfunction

    localparam t_curve_tab CURVE_TAB = f_build_curve();

endpackage

// ===== rtl/core/lowpass_gate_envelope_bank_core.sv =====
// Bank of low-pass-gate envelopes with lowest-level voice stealing. Items enter
// through a two-entry command queue and results leave through a two-entry result
// queue, so both sides may stall on their own. A tick walks the voices one after
// another: a sounding voice passes LEVEL, CHECK, CURVE, MIX, CUT and EMIT, a silent
// one only LEVEL and CHECK, and one that falls silent LEVEL, CHECK and EMIT.
// Registers may be written only while idle.
module lowpass_gate_envelope_bank_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_func,
    input  logic [6:0]  i_pitch,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_voice,
    output logic [6:0]  o_note,
    output logic [14:0] o_volume,
    output logic [12:0] o_cutoff_hz,
    output logic [15:0] o_drive,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    lgeb_pkg::t_cfg    r_cfg;
    lgeb_pkg::t_cmd    w_cmd;
    lgeb_pkg::t_result w_res;
    lgeb_pkg::t_result w_out;
    logic              w_cmd_valid;
    logic              w_cmd_ready;
    logic              w_res_push;
    logic              w_res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decay_factor  <= lgeb_pkg::DECAY_RESET;
            r_cfg.attack_step   <= lgeb_pkg::ATTACK_RESET;
            r_cfg.fold_amount   <= lgeb_pkg::FOLD_RESET;
            r_cfg.couple_amount <= lgeb_pkg::COUPLE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lgeb_pkg::REG_DECAY:  r_cfg.decay_factor  <= i_cfg_data;
                lgeb_pkg::REG_ATTACK: r_cfg.attack_step   <= i_cfg_data;
                lgeb_pkg::REG_FOLD:   r_cfg.fold_amount   <= i_cfg_data;
                lgeb_pkg::REG_COUPLE: r_cfg.couple_amount <= i_cfg_data;
                default:              r_cfg <= r_cfg;
            endcase
        end
    end

    lgeb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_func      (i_func),
        .i_pitch     (i_pitch),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    lgeb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .i_cfg       (r_cfg),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .i_res_full  (w_res_full)
    );

    lgeb_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_out)
    );

    assign o_kind      = w_out.kind;
    assign o_voice     = w_out.voice;
    assign o_note      = w_out.note;
    assign o_volume    = w_out.volume;
    assign o_cutoff_hz = w_out.cutoff_hz;
    assign o_drive     = w_out.drive;
    assign o_last      = w_out.last;

endmodule

// ===== rtl/core/lgeb_front.sv =====
// front end: accepts and classifies items into a two-entry command queue
module lgeb_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic                i_func,
    input  logic [6:0]          i_pitch,
    output logic                o_cmd_valid,
    output lgeb_pkg::t_cmd      o_cmd,
    input  logic                i_cmd_ready
);

    lgeb_pkg::t_cmd r_mem [0:1];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           w_wr;
    logic           w_rd;

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_mem[r_rp];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp].strike <= i_func;
            r_mem[r_wp].pitch  <= i_pitch;
        end
    end

endmodule

// ===== rtl/core/lgeb_outq.sv =====
// two-entry result queue in front of the output ports
module lgeb_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lgeb_pkg::t_result   i_data,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output lgeb_pkg::t_result   o_data
);

    lgeb_pkg::t_result r_mem [0:1];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic              w_wr;
    logic              w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end

endmodule

// ===== rtl/core/lgeb_back.sv =====
// back end: voice state, strike allocation and per-voice tick sequencer
module lgeb_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  lgeb_pkg::t_cmd      i_cmd,
    output logic                o_cmd_ready,
    input  lgeb_pkg::t_cfg      i_cfg,
    output logic                o_res_push,
    output lgeb_pkg::t_result   o_res,
    input  logic                i_res_full
);

    localparam int unsigned NV  = lgeb_pkg::NUM_VOICES;
    localparam int unsigned VW  = lgeb_pkg::VIDX_W;
    localparam int unsigned KW  = lgeb_pkg::KIDX_W;
    localparam int unsigned SW  = 15 + KW;

    lgeb_pkg::t_bstate r_state;
    lgeb_pkg::t_bstate n_state;

    logic [15:0]       r_level [0:NV-1];
    logic [NV-1:0]     r_attacking;
    logic [VW-1:0]     r_v;
    logic [6:0]        r_pitch;
    logic [15:0]       r_lv;
    logic [14:0]       r_vol;
    logic [15:0]       r_drv;
    logic [16:0]       r_ta;
    logic [16:0]       r_tb;
    logic [14:0]       r_f;
    logic [16:0]       r_curve;
    logic [16:0]       r_mix;
    lgeb_pkg::t_result r_new;
    lgeb_pkg::t_result r_pend;
    logic              r_pend_valid;

    logic [VW-1:0]     w_sel;
    logic              w_last_v;
    logic              w_can_emit;
    logic [16:0]       w_sum;
    logic [31:0]       w_dec_prod;
    logic [15:0]       w_lv_next;
    logic              w_attack_done;
    logic [19:0]       w_vol_full;
    logic [31:0]       w_drv_prod;
    logic [16:0]       w_drv_sh;
    logic [SW-1:0]     w_s;
    logic [KW-1:0]     w_k;
    logic [KW-1:0]     w_k1;
    logic [16:0]       w_diff;
    logic [31:0]       w_ip_prod;
    logic [16:0]       w_ip;
    logic [32:0]       w_mix_prod;
    logic [29:0]       w_cut_prod;
    logic [12:0]       w_cut;
    lgeb_pkg::t_result w_strike_res;
    lgeb_pkg::t_result w_sil_res;
    lgeb_pkg::t_result w_lvl_res;

    always_comb begin
        w_sel = '0;
        for (int v = 1; v < int'(NV); v++) begin
            if (r_level[v] < r_level[w_sel]) w_sel = VW'(v);
        end
    end

    assign w_last_v   = (r_v == VW'(NV - 1));
    assign w_can_emit = !r_pend_valid || !i_res_full;

    assign w_sum         = {1'b0, r_level[r_v]} + {1'b0, i_cfg.attack_step};
    assign w_dec_prod    = r_level[r_v] * i_cfg.decay_factor;
    assign w_attack_done = (w_sum >= {1'b0, lgeb_pkg::ONE_Q15});
    always_comb begin
        if (r_attacking[r_v]) begin
            w_lv_next = w_attack_done ? lgeb_pkg::ONE_Q15 : w_sum[15:0];
        end else begin
            w_lv_next = w_dec_prod[31:16];
        end
    end

    assign w_vol_full = ({4'd0, r_lv} << 3) + ({4'd0, r_lv} << 1) + {4'd0, r_lv};
    assign w_drv_prod = i_cfg.fold_amount * r_lv;
    assign w_drv_sh   = w_drv_prod[31:15];

    assign w_s  = SW'(r_lv) * SW'(lgeb_pkg::CURVE_TABLE_SIZE);
    assign w_k  = w_s[SW-1:15];
    assign w_k1 = (w_k == KW'(lgeb_pkg::CURVE_TABLE_SIZE)) ? w_k : w_k + KW'(1);

    assign w_diff    = (r_tb >= r_ta) ? (r_tb - r_ta) : (r_ta - r_tb);
    assign w_ip_prod = w_diff * r_f;
    assign w_ip      = (r_tb >= r_ta) ? (r_ta + w_ip_prod[31:15]) : (r_ta - w_ip_prod[31:15]);

    assign w_mix_prod = i_cfg.couple_amount * r_curve;
    assign w_cut_prod = lgeb_pkg::CUT_SPAN * r_mix;
    assign w_cut      = lgeb_pkg::CUT_BASE + w_cut_prod[28:16];

    always_comb begin
        w_strike_res       = '0;
        w_strike_res.kind  = lgeb_pkg::KIND_PITCH;
        w_strike_res.voice = 4'(w_sel);
        w_strike_res.note  = r_pitch;
        w_strike_res.last  = 1'b1;
    end

    always_comb begin
        w_sil_res       = '0;
        w_sil_res.kind  = lgeb_pkg::KIND_SILENCE;
        w_sil_res.voice = 4'(r_v);
    end

    always_comb begin
        w_lvl_res           = '0;
        w_lvl_res.kind      = lgeb_pkg::KIND_LEVEL;
        w_lvl_res.voice     = 4'(r_v);
        w_lvl_res.volume    = r_vol;
        w_lvl_res.cutoff_hz = w_cut;
        w_lvl_res.drive     = r_drv;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lgeb_pkg::B_IDLE: begin
                if (i_cmd_valid) n_state = i_cmd.strike ? lgeb_pkg::B_STRIKE : lgeb_pkg::B_LEVEL;
            end
            lgeb_pkg::B_STRIKE: begin
                if (!i_res_full) n_state = lgeb_pkg::B_IDLE;
            end
            lgeb_pkg::B_LEVEL: n_state = lgeb_pkg::B_CHECK;
            lgeb_pkg::B_CHECK: begin
                if (r_lv < lgeb_pkg::SILENCE_LIMIT) begin
                    if (r_lv != 16'd0) begin
                        n_state = lgeb_pkg::B_EMIT;
                    end else if (w_last_v) begin
                        n_state = r_pend_valid ? lgeb_pkg::B_STRIKE : lgeb_pkg::B_IDLE;
                    end else begin
                        n_state = lgeb_pkg::B_LEVEL;
                    end
                end else begin
                    n_state = lgeb_pkg::B_CURVE;
                end
            end
            lgeb_pkg::B_CURVE: n_state = lgeb_pkg::B_MIX;
            lgeb_pkg::B_MIX:   n_state = lgeb_pkg::B_CUT;
            lgeb_pkg::B_CUT:   n_state = lgeb_pkg::B_EMIT;
            lgeb_pkg::B_EMIT: begin
                if (w_can_emit) begin
                    if (!w_last_v) begin
                        n_state = lgeb_pkg::B_LEVEL;
                    end else begin
                        n_state = lgeb_pkg::B_STRIKE;
                    end
                end
            end
            default: n_state = lgeb_pkg::B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd_ready = 1'b0;
        o_res_push  = 1'b0;
        o_res       = r_pend;
        case (r_state)
            lgeb_pkg::B_IDLE: o_cmd_ready = 1'b1;
            lgeb_pkg::B_STRIKE: begin
                if (!r_pend_valid) begin
                    o_res      = w_strike_res;
                    o_res_push = 1'b1;
                end else begin
                    o_res.last = 1'b1;
                    o_res_push = 1'b1;
                end
            end
            lgeb_pkg::B_EMIT: begin
                o_res.last = 1'b0;
                o_res_push = r_pend_valid;
            end
            default: o_res_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lgeb_pkg::B_IDLE;
            r_v          <= '0;
            r_pend_valid <= 1'b0;
            r_attacking  <= '0;
            for (int v = 0; v < int'(NV); v++) r_level[v] <= 16'd0;
        end else begin
            r_state <= n_state;
            case (r_state)
                lgeb_pkg::B_IDLE: r_v <= '0;
                lgeb_pkg::B_STRIKE: begin
                    if (!i_res_full) begin
                        if (r_pend_valid) begin
                            r_pend_valid <= 1'b0;
                        end else begin
                            r_attacking[w_sel] <= 1'b1;
                            if (r_level[w_sel] < lgeb_pkg::STRIKE_FLOOR) begin
                                r_level[w_sel] <= lgeb_pkg::STRIKE_FLOOR;
                            end
                        end
                    end
                end
                lgeb_pkg::B_LEVEL: begin
                    if (r_attacking[r_v] && w_attack_done) r_attacking[r_v] <= 1'b0;
                end
                lgeb_pkg::B_CHECK: begin
                    if (r_lv < lgeb_pkg::SILENCE_LIMIT) begin
                        r_level[r_v] <= 16'd0;
                        if (r_lv == 16'd0 && !w_last_v) r_v <= r_v + VW'(1);
                    end else begin
                        r_level[r_v] <= r_lv;
                    end
                end
                lgeb_pkg::B_EMIT: begin
                    if (w_can_emit) begin
                        if (r_lv != 16'd0) begin
                            r_pend_valid <= 1'b1;
                        end
                        if (!w_last_v) r_v <= r_v + VW'(1);
                    end
                end
                default: r_v <= r_v;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            lgeb_pkg::B_IDLE: r_pitch <= i_cmd.pitch;
            lgeb_pkg::B_LEVEL: r_lv <= w_lv_next;
            lgeb_pkg::B_CHECK: begin
                r_vol <= w_vol_full[18:4];
                r_drv <= w_drv_sh[16] ? 16'hFFFF : w_drv_sh[15:0];
                r_ta  <= lgeb_pkg::CURVE_TAB[w_k];
                r_tb  <= lgeb_pkg::CURVE_TAB[w_k1];
                r_f   <= w_s[14:0];
                r_new <= w_sil_res;
            end
            lgeb_pkg::B_CURVE: r_curve <= w_ip;
            lgeb_pkg::B_MIX: r_mix <= (lgeb_pkg::FULL_Q16 - {1'b0, i_cfg.couple_amount})
                                      + w_mix_prod[32:16];
            lgeb_pkg::B_CUT: r_new <= w_lvl_res;
            lgeb_pkg::B_EMIT: begin
                if (w_can_emit && r_lv != 16'd0) r_pend <= r_new;
            end
            default: r_curve <= r_curve;
        endcase
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push && i_res_full |=> $stable(r_state) || r_state == lgeb_pkg::B_IDLE)
        else $error("result pushed into a full queue");
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lgeb_pkg::B_CHECK |-> r_lv <= lgeb_pkg::ONE_Q15)
        else $error("level above full scale");
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lgeb_pkg::B_IDLE |-> !r_pend_valid)
        else $error("pending result left at end of item");
    a_pitch_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push && o_res.kind == lgeb_pkg::KIND_PITCH |-> o_res.last)
        else $error("pitch result not marked last");
`endif

endmodule
